[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[sv/uad_pkg.sv]
// ----------------------------------------------------------------------------
// uad_pkg
// Types, constants and helper functions of the binary to ASCII digit
// converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uad_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int IN_BITS            = 32;
   localparam int NIBBLE_BITS        = 4;
   localparam int DIGITS             = 10;
   localparam int DIGIT_REG_BITS     = DIGITS * NIBBLE_BITS;
   localparam int CHAR_BITS          = 7;
   localparam int IDX_BITS           = $clog2(DIGITS);

   localparam logic [NIBBLE_BITS-1:0] DEC_LIMIT   = 4'h5;
   localparam logic [NIBBLE_BITS-1:0] DEC_ADJUST  = 4'h3;
   localparam logic [NIBBLE_BITS-1:0] HEX_ALPHA   = 4'hA;
   localparam logic [CHAR_BITS-1:0]   CHAR_ZERO   = 7'h30;
   localparam logic [CHAR_BITS-1:0]   CHAR_A      = 7'h41;

   localparam logic KIND_DEC = 1'b0;
   localparam logic KIND_HEX = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   function automatic logic [CHAR_BITS-1:0] ascii_of(input logic [NIBBLE_BITS-1:0] d);
      logic [CHAR_BITS-1:0] c;
      if (d < HEX_ALPHA) begin
         c = CHAR_ZERO + CHAR_BITS'(d);
      end else begin
         c = CHAR_A + CHAR_BITS'(d - HEX_ALPHA);
      end
      return c;
   endfunction

endpackage

[sv/unsigned_to_ascii_digits.sv]
// Decimal runs the shift-and-add-3 conversion over the low min(VALUE_BITS,32)
// bits of req_value, then a scan of the ten digits; hex skips the conversion.
// Busy stays high through both phases, so a new transaction is taken only
// once the block is back in idle; the receiver cannot stall.
// Synchronous active-high reset returns the block to idle with no strobe.
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits
// Converts an unsigned value to ASCII decimal or upper-case hex digits,
// most significant first, without leading zeros.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module unsigned_to_ascii_digits #(
   parameter int VALUE_BITS = uad_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [uad_pkg::IN_BITS-1:0]   req_value,
   output logic                          rsp_valid,
   output logic [uad_pkg::CHAR_BITS-1:0] rsp_digit_char,
   output logic                          rsp_last
);

   import uad_pkg::*;

   localparam int CONV_BITS = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
   localparam int CNT_BITS  = $clog2(CONV_BITS + 1);

   state_type                  state_ff, state_in;
   logic [CONV_BITS-1:0]       bin_ff, bin_in;
   logic [DIGIT_REG_BITS-1:0]  dig_ff, dig_in;
   logic [DIGIT_REG_BITS-1:0]  dig_adj;
   logic [CNT_BITS-1:0]        cnt_ff, cnt_in;
   logic [IDX_BITS-1:0]        idx_ff, idx_in;
   logic                       started_ff, started_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]       rsp_char_ff, rsp_char_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       accept;
   logic [NIBBLE_BITS-1:0]     top_nibble;
   logic                       emit;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign top_nibble = dig_ff[DIGIT_REG_BITS-1 -: NIBBLE_BITS];
   assign emit       = started_ff || (top_nibble != '0) || (idx_ff == '0);

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (dig_ff[i*NIBBLE_BITS +: NIBBLE_BITS] >= DEC_LIMIT) begin
            dig_adj[i*NIBBLE_BITS +: NIBBLE_BITS] =
               dig_ff[i*NIBBLE_BITS +: NIBBLE_BITS] + DEC_ADJUST;
         end else begin
            dig_adj[i*NIBBLE_BITS +: NIBBLE_BITS] = dig_ff[i*NIBBLE_BITS +: NIBBLE_BITS];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_kind == KIND_HEX) ? ST_EMIT : ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (cnt_ff == CNT_BITS'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (idx_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      bin_in       = bin_ff;
      dig_in       = dig_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      started_in   = started_ff;
      rsp_valid_in = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               bin_in     = req_value[CONV_BITS-1:0];
               cnt_in     = CNT_BITS'(CONV_BITS);
               idx_in     = IDX_BITS'(DIGITS - 1);
               started_in = 1'b0;
               if (req_kind == KIND_HEX) begin
                  dig_in = DIGIT_REG_BITS'(req_value[CONV_BITS-1:0]);
               end else begin
                  dig_in = '0;
               end
            end
         end
         ST_CONVERT: begin
            dig_in = {dig_adj[DIGIT_REG_BITS-2:0], bin_ff[CONV_BITS-1]};
            bin_in = bin_ff << 1;
            cnt_in = cnt_ff - CNT_BITS'(1);
         end
         ST_EMIT: begin
            dig_in       = dig_ff << NIBBLE_BITS;
            idx_in       = idx_ff - IDX_BITS'(1);
            started_in   = started_ff || (top_nibble != '0);
            rsp_valid_in = emit;
            rsp_char_in  = ascii_of(top_nibble);
            rsp_last_in  = (idx_ff == '0);
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      dig_ff      <= dig_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      started_ff  <= started_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;

   `ASSERT_SAME(a_char_range, clock, reset, rsp_valid, (rsp_digit_char >= CHAR_ZERO && rsp_digit_char <= 7'h39) || (rsp_digit_char >= CHAR_A && rsp_digit_char <= 7'h46))
   `ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `ASSERT_NEXT(a_last_gap, clock, reset, rsp_valid && rsp_last, !rsp_valid)
   `ASSERT_SAME(a_valid_from_busy, clock, reset, rsp_valid, $past(busy))

endmodule
